FILE: rtl/pid_controller_clamped_integral_assert.svh
// Assertion macros for the PID controller RTL.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message string.
`ifndef PID_CONTROLLER_CLAMPED_INTEGRAL_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_INTEGRAL_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define PIDCI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define PIDCI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PIDCI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PIDCI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/pidci_pkg.sv
`default_nettype none

package pidci_pkg;

  // Field widths
  localparam int unsigned DataW    = 32;  // setpoint, measured, drive (Q16.16)
  localparam int unsigned GainW    = 32;  // Q8.24 gains
  localparam int unsigned LimW     = 31;  // limit and threshold magnitudes
  localparam int unsigned ErrW     = DataW + 1;
  localparam int unsigned IntegW   = 32;
  localparam int unsigned WideW    = ErrW + 1;  // integral pre-clamp, error delta
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Product and sum widths
  localparam int unsigned FracW   = 24;
  localparam int unsigned PropW   = GainW + ErrW;
  localparam int unsigned IntPW   = GainW + IntegW;
  localparam int unsigned DerPW   = GainW + WideW;
  localparam int unsigned SumW    = DerPW + 2;
  localparam int unsigned ScaledW = SumW - FracW;

  // Register reset values
  localparam logic signed [GainW-1:0] KpReset      = 32'sd8388608;
  localparam logic signed [GainW-1:0] KiReset      = 32'sd16777;
  localparam logic signed [GainW-1:0] KdReset      = 32'sd0;
  localparam logic [LimW-1:0]         IntLimReset  = 31'd454164;
  localparam logic [LimW-1:0]         DbThrReset   = 31'd0;

  localparam logic signed [SumW-1:0]  RoundHalf = SumW'(1) <<< (FracW - 1);
  localparam logic signed [DataW-1:0] DriveMax  = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] DriveMin  = {1'b1, {(DataW-1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP        = 3'd0,
    CFG_KI        = 3'd1,
    CFG_KD        = 3'd2,
    CFG_INT_LIMIT = 3'd3,
    CFG_DB_ENABLE = 3'd4,
    CFG_DB_THRESH = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [GainW-1:0] kp;
    logic signed [GainW-1:0] ki;
    logic signed [GainW-1:0] kd;
    logic [LimW-1:0]         int_limit;
    logic                    db_enable;
    logic [LimW-1:0]         db_thresh;
  } cfg_t;

  // Per-sample operands handed from the state stage to the multipliers
  typedef struct packed {
    logic signed [ErrW-1:0]   err;
    logic signed [IntegW-1:0] integ;
    logic signed [WideW-1:0]  derr;
    logic                     deadband;
  } terms_t;

endpackage

`default_nettype wire

FILE: rtl/pidci_state.sv
`default_nettype none

module pidci_state (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire pidci_pkg::cfg_t                    cfg,
  input  wire logic signed [pidci_pkg::DataW-1:0] setpoint,
  input  wire logic signed [pidci_pkg::DataW-1:0] measured,
  input  wire logic                               step,
  output pidci_pkg::terms_t                       terms
);
  import pidci_pkg::*;

  logic signed [IntegW-1:0] integral_sum_r;
  logic signed [ErrW-1:0]   prev_err_r;

  logic signed [ErrW-1:0]   err;
  logic [ErrW-1:0]          mag;
  logic                     deadband;
  logic signed [WideW-1:0]  integ_raw;
  logic signed [WideW-1:0]  lim_pos;
  logic signed [WideW-1:0]  lim_neg;
  logic signed [WideW-1:0]  integ_clamped;
  logic signed [WideW-1:0]  derr;

  // Form the error and its magnitude
  assign err = ErrW'(setpoint) - ErrW'(measured);
  assign mag = err[ErrW-1] ? $unsigned(-err) : $unsigned(err);
  assign deadband = cfg.db_enable && (mag < ErrW'(cfg.db_thresh));

  // Accumulate and clamp to the symmetric limit
  assign integ_raw = WideW'(integral_sum_r) + WideW'(err);
  assign lim_pos   = $signed(WideW'(cfg.int_limit));
  assign lim_neg   = -lim_pos;

  always_comb begin
    integ_clamped = integ_raw;
    if (integ_raw > lim_pos) begin
      integ_clamped = lim_pos;
    end
    if (integ_raw < lim_neg) begin
      integ_clamped = lim_neg;
    end
  end

  assign derr = WideW'(err) - WideW'(prev_err_r);

  assign terms.err      = err;
  assign terms.integ    = integ_clamped[IntegW-1:0];
  assign terms.derr     = derr;
  assign terms.deadband = deadband;

  // Advance the loop state; hold it on a deadband hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_sum_r <= '0;
      prev_err_r     <= '0;
    end else if (step && !deadband) begin
      integral_sum_r <= integ_clamped[IntegW-1:0];
      prev_err_r     <= err;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pid_controller_clamped_integral.sv
`default_nettype none
`include "pid_controller_clamped_integral_assert.svh"

// Positional PID step in Q16.16 with Q8.24 gains, clamped integral and optional
// error deadband. One sample is taken per clock while in_ready is high. After
// transfer a sample moves through the input register, operand register, product
// register and output register, 4 register stages in all. The rate is set by
// the integral and previous-error update, which closes within the operand stage.
// The stages advance independently, so the input keeps taking samples while a
// result waits as long as a bubble remains. The user must write registers through
// the cfg port only while no sample is in flight; the block does not enforce it.
module pid_controller_clamped_integral (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Configuration writes
  input  wire logic                                 cfg_we,
  input  wire logic [pidci_pkg::CfgIdxW-1:0]        cfg_index,
  input  wire logic [pidci_pkg::CfgDataW-1:0]       cfg_data,
  // Samples
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [pidci_pkg::DataW-1:0]   in_setpoint,
  input  wire logic signed [pidci_pkg::DataW-1:0]   in_measured,
  // Results
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [pidci_pkg::DataW-1:0]        out_drive,
  output logic                                      out_saturated,
  output logic                                      out_in_deadband
);
  import pidci_pkg::*;

  cfg_t cfg_r;

  logic                     s1_valid_r;
  logic signed [DataW-1:0]  s1_setpoint_r;
  logic signed [DataW-1:0]  s1_measured_r;

  logic                     s2_valid_r;
  terms_t                   s2_terms_r;
  terms_t                   terms;

  logic                     s3_valid_r;
  logic signed [PropW-1:0]  prod_p_r;
  logic signed [IntPW-1:0]  prod_i_r;
  logic signed [DerPW-1:0]  prod_d_r;
  logic                     s3_db_r;
  logic signed [PropW-1:0]  prod_p_nxt;
  logic signed [IntPW-1:0]  prod_i_nxt;
  logic signed [DerPW-1:0]  prod_d_nxt;

  logic                     out_valid_r;
  logic signed [DataW-1:0]  out_drive_r;
  logic                     out_saturated_r;
  logic                     out_in_deadband_r;
  logic signed [DataW-1:0]  drive_nxt;
  logic                     saturated_nxt;

  logic signed [SumW-1:0]    sum;
  logic signed [ScaledW-1:0] scaled;
  logic                      overflow;

  logic out_adv;
  logic s3_adv;
  logic s2_adv;
  logic s1_adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp        <= KpReset;
      cfg_r.ki        <= KiReset;
      cfg_r.kd        <= KdReset;
      cfg_r.int_limit <= IntLimReset;
      cfg_r.db_enable <= 1'b0;
      cfg_r.db_thresh <= DbThrReset;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KP:        cfg_r.kp        <= cfg_data;
        CFG_KI:        cfg_r.ki        <= cfg_data;
        CFG_KD:        cfg_r.kd        <= cfg_data;
        CFG_INT_LIMIT: cfg_r.int_limit <= cfg_data[LimW-1:0];
        CFG_DB_ENABLE: cfg_r.db_enable <= cfg_data[0];
        CFG_DB_THRESH: cfg_r.db_thresh <= cfg_data[LimW-1:0];
        default: ;
      endcase
    end
  end

  // Stage advance: a stage moves when empty or when the next one moves
  assign out_adv  = !out_valid_r || out_ready;
  assign s3_adv   = !s3_valid_r || out_adv;
  assign s2_adv   = !s2_valid_r || s3_adv;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= in_valid;
      end
      if (s2_adv) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_adv) begin
        s3_valid_r <= s2_valid_r;
      end
      if (out_adv) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  // Capture the sample on transfer
  always_ff @(posedge clk) begin
    if (in_valid && s1_adv) begin
      s1_setpoint_r <= in_setpoint;
      s1_measured_r <= in_measured;
    end
  end

  // Error, clamped integral and error delta; loop state lives here
  pidci_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .setpoint (s1_setpoint_r),
    .measured (s1_measured_r),
    .step     (s1_valid_r && s2_adv),
    .terms    (terms)
  );

  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_adv) begin
      s2_terms_r <= terms;
    end
  end

  // Three gain products in parallel
  assign prod_p_nxt = $signed(cfg_r.kp) * $signed(s2_terms_r.err);
  assign prod_i_nxt = $signed(cfg_r.ki) * $signed(s2_terms_r.integ);
  assign prod_d_nxt = $signed(cfg_r.kd) * $signed(s2_terms_r.derr);

  always_ff @(posedge clk) begin
    if (s2_valid_r && s3_adv) begin
      prod_p_r <= prod_p_nxt;
      prod_i_r <= prod_i_nxt;
      prod_d_r <= prod_d_nxt;
      s3_db_r  <= s2_terms_r.deadband;
    end
  end

  // Sum, round to nearest with ties up, then saturate; a deadband hit forces zero
  assign sum      = SumW'(prod_p_r) + SumW'(prod_i_r) + SumW'(prod_d_r) + RoundHalf;
  assign scaled   = sum[SumW-1:FracW];
  assign overflow = (scaled[ScaledW-1:DataW-1] != '0) && (scaled[ScaledW-1:DataW-1] != '1);

  always_comb begin
    drive_nxt     = scaled[DataW-1:0];
    saturated_nxt = 1'b0;
    if (s3_db_r) begin
      drive_nxt = '0;
    end else if (overflow) begin
      drive_nxt     = scaled[ScaledW-1] ? DriveMin : DriveMax;
      saturated_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid_r && out_adv) begin
      out_drive_r       <= drive_nxt;
      out_saturated_r   <= saturated_nxt;
      out_in_deadband_r <= s3_db_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive       = out_drive_r;
  assign out_saturated   = out_saturated_r;
  assign out_in_deadband = out_in_deadband_r;

  `PIDCI_ASSERT_IMP(a_db_zero, clk, rst_n, out_valid_r && out_in_deadband_r, out_drive_r == '0 && !out_saturated_r, "deadband result carries nonzero drive")
  `PIDCI_ASSERT_IMP(a_sat_rail, clk, rst_n, out_valid_r && out_saturated_r, out_drive_r == DriveMax || out_drive_r == DriveMin, "saturated drive not at a rail")
  `PIDCI_ASSERT_NXT(a_in_lands, clk, rst_n, in_valid && in_ready, s1_valid_r, "transferred sample missing from input stage")

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import pidci_pkg::*;

  // Index that maps to no register; writes to it must be ignored
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;
  // Half an output LSB in the Q.40 product sum
  localparam logic signed [79:0] HalfLsb = 80'sd8388608;

  typedef struct packed {
    logic signed [DataW-1:0] drive;
    logic                    saturated;
    logic                    in_deadband;
  } drive_result_t;

  typedef enum logic [1:0] {
    ROW_SAMPLE,  // expected result comes from the predictor
    ROW_PINNED,  // expected result typed into the row
    ROW_WRITE    // register write: reg_idx and a carry index and data
  } row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CfgIdxW-1:0]      reg_idx;
    logic [31:0]             a;
    logic [31:0]             b;
    logic signed [DataW-1:0] drive;
    logic                    saturated;
    logic                    in_deadband;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CfgIdxW-1:0]       cfg_index = '0;
  logic [CfgDataW-1:0]      cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DataW-1:0]  in_setpoint = '0;
  logic signed [DataW-1:0]  in_measured = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DataW-1:0]  out_drive;
  logic                     out_saturated;
  logic                     out_in_deadband;

  // Controller copy: gains, limits and loop state
  logic signed [31:0] kp_q = 32'sd8388608;
  logic signed [31:0] ki_q = 32'sd16777;
  logic signed [31:0] kd_q = 32'sd0;
  logic [30:0]        lim_q = 31'd454164;
  logic               db_on = 1'b0;
  logic [30:0]        db_thr = 31'd0;
  logic signed [31:0] integral_acc = 32'sd0;
  logic signed [32:0] last_err = 33'sd0;

  drive_result_t pending_drives[$];
  int unsigned   drive_mismatches = 0;
  int unsigned   sender_idle_pct = 17;
  int unsigned   receiver_idle_pct = 47;

  localparam int DirectedRows = 45;
  stim_row_t directed_rows [DirectedRows] = '{
    // reset gains: zero in, then both full-scale error extremes
    '{ROW_PINNED, CFG_KP, 32'h0000_0000, 32'h0000_0000, 32'sh0000_0000, 1'b0, 1'b0},
    '{ROW_PINNED, CFG_KP, 32'h7FFF_FFFF, 32'h8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b0},
    '{ROW_PINNED, CFG_KP, 32'h8000_0000, 32'h7FFF_FFFF, 32'sh8000_0000, 1'b1, 1'b0},
    '{ROW_SAMPLE, CFG_KP, 32'h0001_0000, 32'h0000_0000, 32'sh0, 1'b0, 1'b0},
    '{ROW_SAMPLE, CFG_KP, 32'h0005_0000, 32'h0001_0000, 32'sh0, 1'b0, 1'b0},
    // derivative term on
    '{ROW_WRITE,  CFG_KD, 32'h0100_0000, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_SAMPLE, CFG_KP, 32'h0003_0000, 32'h0000_0000, 32'sh0, 1'b0, 1'b0},
    '{ROW_SAMPLE, CFG_KP, 32'h0000_0000, 32'h0002_0000, 32'sh0, 1'b0, 1'b0},
    // lower the limit, still above the held integral, then to zero
    '{ROW_WRITE,  CFG_INT_LIMIT, 32'h0001_0000, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_SAMPLE, CFG_KP, 32'h0000_0000, 32'h0000_0000, 32'sh0, 1'b0, 1'b0},
    '{ROW_WRITE,  CFG_INT_LIMIT, 32'h0000_0000, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_SAMPLE, CFG_KP, 32'h0010_0000, 32'h0000_0000, 32'sh0, 1'b0, 1'b0},
    // deadband on with zero threshold never hits
    '{ROW_WRITE,  CFG_DB_ENABLE, 32'h0000_0001, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_SAMPLE, CFG_KP, 32'h0000_0000, 32'h0000_0000, 32'sh0, 1'b0, 1'b0},
    // threshold 2.0: inside hits, the edge itself does not
    '{ROW_WRITE,  CFG_DB_THRESH, 32'h0002_0000, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_PINNED, CFG_KP, 32'h0001_0000, 32'h0001_0000, 32'sh0, 1'b0, 1'b1},
    '{ROW_PINNED, CFG_KP, 32'h0001_FFFF, 32'h0000_0000, 32'sh0, 1'b0, 1'b1},
    '{ROW_PINNED, CFG_KP, 32'h0000_0000, 32'h0001_FFFF, 32'sh0, 1'b0, 1'b1},
    '{ROW_SAMPLE, CFG_KP, 32'h0002_0000, 32'h0000_0000, 32'sh0, 1'b0, 1'b0},
    '{ROW_SAMPLE, CFG_KP, 32'h0000_0000, 32'h0002_0000, 32'sh0, 1'b0, 1'b0},
    // widest threshold
    '{ROW_WRITE,  CFG_DB_THRESH, 32'h7FFF_FFFF, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_PINNED, CFG_KP, 32'h7FFF_FFFF, 32'h0000_0001, 32'sh0, 1'b0, 1'b1},
    '{ROW_SAMPLE, CFG_KP, 32'h7FFF_FFFF, 32'h0000_0000, 32'sh0, 1'b0, 1'b0},
    '{ROW_SAMPLE, CFG_KP, 32'h8000_0000, 32'h7FFF_FFFF, 32'sh0, 1'b0, 1'b0},
    // upper data bits are dropped: enable goes to 0, limit to full scale
    '{ROW_WRITE,  CFG_DB_ENABLE, 32'hFFFF_FFFE, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_WRITE,  CFG_KP, 32'h8000_0000, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_WRITE,  CFG_KI, 32'h7FFF_FFFF, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_WRITE,  CFG_KD, 32'h8000_0000, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_WRITE,  CFG_INT_LIMIT, 32'hFFFF_FFFF, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_SAMPLE, CFG_KP, 32'h7FFF_FFFF, 32'h8000_0000, 32'sh0, 1'b0, 1'b0},
    '{ROW_SAMPLE, CFG_KP, 32'h8000_0000, 32'h7FFF_FFFF, 32'sh0, 1'b0, 1'b0},
    '{ROW_SAMPLE, CFG_KP, 32'h0000_0001, 32'h0000_0000, 32'sh0, 1'b0, 1'b0},
    '{ROW_WRITE,  CFG_KP, 32'h7FFF_FFFF, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_WRITE,  CFG_KI, 32'h8000_0000, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_WRITE,  CFG_KD, 32'h7FFF_FFFF, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_SAMPLE, CFG_KP, 32'h8000_0000, 32'h7FFF_FFFF, 32'sh0, 1'b0, 1'b0},
    '{ROW_SAMPLE, CFG_KP, 32'hFFFF_FFFF, 32'h0000_0000, 32'sh0, 1'b0, 1'b0},
    // write to an unmapped index, then zero all gains
    '{ROW_WRITE,  CfgUnused, 32'h1234_5678, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_WRITE,  CFG_KP, 32'h0000_0000, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_WRITE,  CFG_KI, 32'h0000_0000, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_WRITE,  CFG_KD, 32'h0000_0000, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_PINNED, CFG_KP, 32'h7FFF_FFFF, 32'h8000_0000, 32'sh0, 1'b0, 1'b0},
    // half-LSB ties round toward plus infinity
    '{ROW_WRITE,  CFG_KP, 32'h0080_0000, 32'h0, 32'sh0, 1'b0, 1'b0},
    '{ROW_PINNED, CFG_KP, 32'h0000_0001, 32'h0000_0000, 32'sh1, 1'b0, 1'b0},
    '{ROW_PINNED, CFG_KP, 32'h0000_0000, 32'h0000_0001, 32'sh0, 1'b0, 1'b0}
  };

  pid_controller_clamped_integral dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_setpoint     (in_setpoint),
    .in_measured     (in_measured),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_drive       (out_drive),
    .out_saturated   (out_saturated),
    .out_in_deadband (out_in_deadband)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // One controller step: deadband test, clamped integral, rounded and saturated sum
  function automatic drive_result_t predict_drive(input logic signed [31:0] sp,
                                                  input logic signed [31:0] ms);
    logic signed [32:0] err;
    logic [32:0]        mag;
    logic signed [33:0] acc;
    logic signed [33:0] lim;
    logic signed [33:0] derr;
    logic signed [79:0] total;
    drive_result_t      r;
    err = sp - ms;
    mag = err[32] ? -err : err;
    r = '0;
    if (db_on && mag < {2'b00, db_thr}) begin
      r.in_deadband = 1'b1;
      return r;
    end
    acc = integral_acc + err;
    lim = {3'b000, lim_q};
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    derr = err - last_err;
    total = kp_q * err + ki_q * acc + kd_q * derr + HalfLsb;
    total = total >>> 24;
    if (total > DriveMax) begin
      r.drive = DriveMax;
      r.saturated = 1'b1;
    end else if (total < DriveMin) begin
      r.drive = DriveMin;
      r.saturated = 1'b1;
    end else begin
      r.drive = total[31:0];
    end
    integral_acc = acc[31:0];
    last_err = err;
    return r;
  endfunction

  // Write one register and mirror it; the port drops bits above each width
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_KP:        kp_q = data;
      CFG_KI:        ki_q = data;
      CFG_KD:        kd_q = data;
      CFG_INT_LIMIT: lim_q = data[30:0];
      CFG_DB_ENABLE: db_on = data[0];
      CFG_DB_THRESH: db_thr = data[30:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hold off the sender until every outstanding result has been transferred
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_drives.size() != 0);
  endtask

  // Offer one sample, hold it until transferred, then queue its expected result
  task automatic send_sample(input logic signed [31:0] sp, input logic signed [31:0] ms,
                             input logic pinned, input drive_result_t pin_res);
    drive_result_t res;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_setpoint <= sp;
    in_measured <= ms;
    do @(posedge clk); while (!in_ready);
    res = predict_drive(sp, ms);
    pending_drives.push_back(pinned ? pin_res : res);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      2: return $urandom_range(0, 1) ? DriveMax : DriveMin;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h000F_FFFF);
      2: return 32'h0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_threshold();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return $urandom_range(1, 32'h0003_FFFF);
      2: return $urandom;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_level();
    case ($urandom_range(0, 5))
      0: return DriveMax;
      1: return DriveMin;
      2: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic program_random_settings();
    write_reg(CFG_KP, pick_gain());
    write_reg(CFG_KI, pick_gain());
    write_reg(CFG_KD, pick_gain());
    write_reg(CFG_INT_LIMIT, pick_limit());
    write_reg(CFG_DB_ENABLE, $urandom);
    write_reg(CFG_DB_THRESH, pick_threshold());
    if ($urandom_range(0, 3) == 0) write_reg(CfgUnused, $urandom);
  endtask

  // Half the errors near the deadband edge, the rest anywhere in range
  task automatic send_random_sample();
    logic signed [31:0] sp;
    logic signed [31:0] ms;
    logic [31:0]        span;
    logic [31:0]        offset;
    sp = pick_level();
    case ($urandom_range(0, 3))
      0, 1: begin
        span = (db_thr != 0) ? {db_thr, 1'b0} : 32'h0004_0000;
        offset = $urandom_range(0, span);
        ms = sp - offset + (span >> 1);
      end
      2: ms = pick_level();
      default: ms = $urandom;
    endcase
    send_sample(sp, ms, 1'b0, '0);
  endtask

  // Stall the result side at the current rate
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    drive_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected result drive %h saturated %b in_deadband %b",
                 $time, out_drive, out_saturated, out_in_deadband);
        drive_mismatches++;
      end else begin
        want = pending_drives.pop_front();
        if (out_drive !== want.drive) begin
          $display("%0t: drive expected %h actual %h", $time, want.drive, out_drive);
          drive_mismatches++;
        end
        if (out_saturated !== want.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                   out_saturated);
          drive_mismatches++;
        end
        if (out_in_deadband !== want.in_deadband) begin
          $display("%0t: in_deadband expected %b actual %b", $time, want.in_deadband,
                   out_in_deadband);
          drive_mismatches++;
        end
      end
    end
  end

  // Stimulus: directed table, then random blocks under changing settings and stalls
  initial begin
    drive_result_t pin;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      pin = '{directed_rows[i].drive, directed_rows[i].saturated,
              directed_rows[i].in_deadband};
      case (directed_rows[i].kind)
        ROW_WRITE: begin
          wait_for_results();
          write_reg(directed_rows[i].reg_idx, directed_rows[i].a);
        end
        ROW_PINNED: send_sample(directed_rows[i].a, directed_rows[i].b, 1'b1, pin);
        default: send_sample(directed_rows[i].a, directed_rows[i].b, 1'b0, pin);
      endcase
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 17;
          receiver_idle_pct = 47;
        end
        1: begin
          sender_idle_pct = 47;
          receiver_idle_pct = 17;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        wait_for_results();
        program_random_settings();
        repeat (100) send_random_sample();
      end
    end

    // Drain, then allow the pipeline depth for stray results
    wait_for_results();
    repeat (8) @(posedge clk);
    if (drive_mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
